/* rtl/bldc_pkg.sv */
// ----------------------------------------------------------------------------
// bldc_pkg
// Shared types and constants for the bicolor LED dimmer control block.
// ----------------------------------------------------------------------------
package bldc_pkg;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'd255;
  localparam logic [DUTY_W-1:0]  PERCENT         = 7'd100;
  localparam logic [LEVEL_W-1:0] SCALE_ROUND     = 8'd255;
  localparam logic [LEVEL_W-1:0] BRI_STEP_RST    = 8'd8;
  localparam logic [LEVEL_W-1:0] TMP_STEP_RST    = 8'd4;
  localparam logic [LEVEL_W-1:0] BRI_RST         = 8'd64;
  localparam logic [LEVEL_W-1:0] TMP_RST         = 8'd128;

  // request codes
  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_ENCODER = 2'd1;
  localparam logic [1:0] REQ_BTN1    = 2'd2;
  localparam logic [1:0] REQ_BTN2    = 2'd3;

  // knob modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_BRI  = 2'd1;
  localparam logic [1:0] MODE_TMP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRI_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TMP_STEP = 1'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [LEVEL_W-1:0] bri;
    logic [LEVEL_W-1:0] tmp;
  } lvl_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] bri_step;
    logic [LEVEL_W-1:0] tmp_step;
  } step_cfg_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [LEVEL_W-1:0]        new_bri;
    logic [LEVEL_W-1:0]        new_tmp;
    logic signed [COUNT_W-1:0] count;
  } req_word_t;

endpackage

/* rtl/bldc_req_if.sv */
// ----------------------------------------------------------------------------
// bldc_req_if
// Request channel: one word per knob, button or direct set event.
// ----------------------------------------------------------------------------
interface bldc_req_if
  import bldc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [LEVEL_W-1:0]        new_brightness;
  logic [LEVEL_W-1:0]        new_temperature;
  logic signed [COUNT_W-1:0] encoder_count;

  modport source (output valid, req_type, new_brightness, new_temperature, encoder_count,
                  input ready);
  modport sink   (input valid, req_type, new_brightness, new_temperature, encoder_count,
                  output ready);
endinterface

/* rtl/bldc_rsp_if.sv */
// ----------------------------------------------------------------------------
// bldc_rsp_if
// Response channel: mode, both levels and the two channel duties.
// ----------------------------------------------------------------------------
interface bldc_rsp_if
  import bldc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         knob_mode;
  logic [LEVEL_W-1:0] brightness_level;
  logic [LEVEL_W-1:0] temperature_level;
  logic [DUTY_W-1:0]  duty_a;
  logic [DUTY_W-1:0]  duty_b;

  modport source (output valid, knob_mode, brightness_level, temperature_level, duty_a, duty_b,
                  input ready);
  modport sink   (input valid, knob_mode, brightness_level, temperature_level, duty_a, duty_b,
                  output ready);
endinterface

/* rtl/bldc_cfg_if.sv */
// ----------------------------------------------------------------------------
// bldc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bldc_cfg_if
  import bldc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEVEL_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bldc_update.sv */
// ----------------------------------------------------------------------------
// bldc_update
// Next-state logic: direct set, mode buttons and saturating encoder steps.
// ----------------------------------------------------------------------------
module bldc_update
  import bldc_pkg::*;
(
  input  req_word_t  word,
  input  lvl_state_t cur,
  input  step_cfg_t  steps,
  output lvl_state_t nxt
);

  logic               up;
  logic               on_bri;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] stepped;

  // a count of at least one means increase
  assign up     = !word.count[COUNT_W-1] && (word.count != '0);
  assign on_bri = (cur.mode == MODE_BRI);
  assign level  = on_bri ? cur.bri : cur.tmp;
  assign step   = on_bri ? steps.bri_step : steps.tmp_step;
  assign sum    = {1'b0, level} + {1'b0, step};

  always_comb begin
    if (up) begin
      stepped = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
    end else begin
      stepped = (level > step) ? (level - step) : '0;
    end
  end

  always_comb begin
    nxt = cur;
    case (word.req_type)
      REQ_SET: begin
        nxt.bri = word.new_bri;
        nxt.tmp = word.new_tmp;
      end
      REQ_ENCODER: begin
        // ignore the knob when no mode is selected
        if (on_bri) begin
          nxt.bri = stepped;
        end else if (cur.mode != MODE_NONE) begin
          nxt.tmp = stepped;
        end
      end
      REQ_BTN1: nxt.mode = MODE_BRI;
      REQ_BTN2: nxt.mode = MODE_TMP;
      default:  nxt = cur;
    endcase
  end

endmodule

/* rtl/bicolor_led_dimmer_control_core.sv */
// ----------------------------------------------------------------------------
// bicolor_led_dimmer_control_core
// Bicolor LED dimmer: level state, knob mode and channel duty computation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event per word: direct set of both levels, encoder report,
//   or one of two mode buttons. rsp returns exactly one word per request with
//   the knob mode, both levels after the event and the two duties in percent.
//   cfg writes the brightness step (index 0) or temperature step (index 1);
//   cfg.ready is always high, and writes belong to idle periods.
// Timing:
//   Three register stages: input word, updated state plus temperature share,
//   then the duty word. rsp.valid rises once an accepted request reaches the
//   third stage, and one request is taken every cycle while rsp.ready stays
//   high. The rate is set by the state update from the input stage to the
//   second stage, which the next word sees from the state register.
// Reset:
//   rst clears all stages; brightness 64, temperature 128, no knob mode,
//   steps 8 and 4.
// Stall:
//   while rsp.ready is low the stages fill up and req.ready falls once all
//   three hold a word; nothing is dropped.
// ----------------------------------------------------------------------------
module bicolor_led_dimmer_control_core
  import bldc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  bldc_req_if.sink   req,
  bldc_rsp_if.source rsp,
  bldc_cfg_if.sink   cfg
);

  // stage valids and advance strobes
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // architectural state
  lvl_state_t state;
  lvl_state_t state_next;
  step_cfg_t  steps;

  // stage 1: input word
  req_word_t word;

  // stage 2: snapshot of the state after the word, plus the temperature share
  lvl_state_t snap;
  logic [DUTY_W-1:0] share_a;

  // share and product computation for stages 2 and 3
  logic [2*LEVEL_W-1:0] tmp_prod;
  logic [DUTY_W-1:0]    share_a_next;
  logic [DUTY_W-1:0]    share_b;
  logic [2*LEVEL_W-1:0] prod_a;
  logic [2*LEVEL_W-1:0] prod_b;

  assign adv3 = v3 && rsp.ready;
  assign adv2 = v2 && (!v3 || adv3);
  assign adv1 = v1 && (!v2 || adv2);

  assign req.ready = !v1 || adv1;
  assign cfg.ready = 1'b1;

  bldc_update u_update (
    .word  (word),
    .cur   (state),
    .steps (steps),
    .nxt   (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steps.bri_step <= BRI_STEP_RST;
      steps.tmp_step <= TMP_STEP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BRI_STEP: steps.bri_step <= cfg.data;
        CFG_TMP_STEP: steps.tmp_step <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (req.ready) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      word.req_type <= req.req_type;
      word.new_bri  <= req.new_brightness;
      word.new_tmp  <= req.new_temperature;
      word.count    <= req.encoder_count;
    end
  end

  // a = ceil(t*100/256)
  assign tmp_prod     = state_next.tmp * {{(LEVEL_W+1){1'b0}}, PERCENT};
  assign share_a_next = DUTY_W'((tmp_prod + {{LEVEL_W{1'b0}}, SCALE_ROUND}) >> LEVEL_W);

  // stage 2: commit the state as the word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      v2          <= 1'b0;
      state.mode  <= MODE_NONE;
      state.bri   <= BRI_RST;
      state.tmp   <= TMP_RST;
    end else begin
      if (adv1) begin
        state <= state_next;
      end
      if (adv1 || adv2) begin
        v2 <= adv1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      snap    <= state_next;
      share_a <= share_a_next;
    end
  end

  // duty = ceil(share*brightness/256)
  assign share_b = PERCENT - share_a;
  assign prod_a  = {{(LEVEL_W+1){1'b0}}, share_a} * {{LEVEL_W{1'b0}}, snap.bri};
  assign prod_b  = {{(LEVEL_W+1){1'b0}}, share_b} * {{LEVEL_W{1'b0}}, snap.bri};

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv2 || adv3) begin
      v3 <= adv2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      rsp.knob_mode         <= snap.mode;
      rsp.brightness_level  <= snap.bri;
      rsp.temperature_level <= snap.tmp;
      rsp.duty_a <= DUTY_W'((prod_a + {{LEVEL_W{1'b0}}, SCALE_ROUND}) >> LEVEL_W);
      rsp.duty_b <= DUTY_W'((prod_b + {{LEVEL_W{1'b0}}, SCALE_ROUND}) >> LEVEL_W);
    end
  end

  assign rsp.valid = v3;

`ifndef SYNTHESIS
  // the stored mode never takes the unused code
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_NONE) || (state.mode == MODE_BRI) || (state.mode == MODE_TMP))
    else $error("knob mode holds an unused code");

  // state moves only when a word leaves the input stage
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv1 |=> $stable(state))
    else $error("state changed without a word advancing");

  // duties stay within percent range
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (rsp.duty_a <= PERCENT) && (rsp.duty_b <= PERCENT))
    else $error("duty out of range");

  // a word moving into stage 2 always had room
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    adv1 |-> (!v2 || adv2))
    else $error("stage 2 overrun");
`endif

endmodule

/* tb/sv/bldc_checker.sv */
// ----------------------------------------------------------------------------
// bldc_checker
// Watches the request, response and configuration channels of the dimmer
// core. It keeps its own copy of the levels, knob mode and step registers,
// and predicts the response word for every accepted request. Each accepted
// response is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bldc_checker
  import bldc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bldc_req_if  req,
  bldc_rsp_if  rsp,
  bldc_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         mode;
    logic [LEVEL_W-1:0] bri;
    logic [LEVEL_W-1:0] tmp;
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
  } lamp_out_t;

  lamp_out_t  lamp_out_q[$];
  lvl_state_t lamp_state;
  step_cfg_t  knob_steps;
  int         fail_cnt = 0;
  int         open_cnt = 0;

  assign errors  = fail_cnt;
  assign pending = open_cnt;

  function automatic logic [LEVEL_W-1:0] saturating_step(logic [LEVEL_W-1:0] level,
                                                         logic up, logic [LEVEL_W-1:0] step);
    int v;
    v = int'(level);
    if (up) begin
      v = v + int'(step);
      if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
    end else begin
      v = (v > int'(step)) ? v - int'(step) : 0;
    end
    return v[LEVEL_W-1:0];
  endfunction

  function automatic lvl_state_t apply_request(lvl_state_t s, step_cfg_t c,
                                               logic [1:0] kind,
                                               logic [LEVEL_W-1:0] nb,
                                               logic [LEVEL_W-1:0] nt,
                                               logic [COUNT_W-1:0] cnt);
    logic up;
    // increase only for a strictly positive count
    up = !cnt[COUNT_W-1] && (cnt != '0);
    case (kind)
      REQ_SET: begin
        s.bri = nb;
        s.tmp = nt;
      end
      REQ_ENCODER: begin
        if (s.mode == MODE_BRI) s.bri = saturating_step(s.bri, up, c.bri_step);
        else if (s.mode != MODE_NONE) s.tmp = saturating_step(s.tmp, up, c.tmp_step);
      end
      REQ_BTN1: s.mode = MODE_BRI;
      default:  s.mode = MODE_TMP;
    endcase
    return s;
  endfunction

  function automatic lamp_out_t lamp_result(lvl_state_t s);
    lamp_out_t r;
    int        share_a;
    share_a  = (int'(s.tmp) * int'(PERCENT) + int'(SCALE_ROUND)) >> LEVEL_W;
    r.mode   = s.mode;
    r.bri    = s.bri;
    r.tmp    = s.tmp;
    r.duty_a = DUTY_W'((share_a * int'(s.bri) + int'(SCALE_ROUND)) >> LEVEL_W);
    r.duty_b = DUTY_W'(((int'(PERCENT) - share_a) * int'(s.bri) + int'(SCALE_ROUND))
                       >> LEVEL_W);
    return r;
  endfunction

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      if (fail_cnt < 100)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    lamp_out_t want;
    if (rst) begin
      lamp_state = '{mode: MODE_NONE, bri: BRI_RST, tmp: TMP_RST};
      knob_steps = '{bri_step: BRI_STEP_RST, tmp_step: TMP_STEP_RST};
      lamp_out_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BRI_STEP: knob_steps.bri_step = cfg.data;
          CFG_TMP_STEP: knob_steps.tmp_step = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        lamp_state = apply_request(lamp_state, knob_steps, req.req_type, req.new_brightness,
                                   req.new_temperature, req.encoder_count);
        lamp_out_q.push_back(lamp_result(lamp_state));
      end
      if (rsp.valid && rsp.ready) begin
        if (lamp_out_q.size() == 0) begin
          if (fail_cnt < 100)
            $display("%0t: response word with no request open, expected none, got %h",
                     $time, {rsp.knob_mode, rsp.brightness_level, rsp.temperature_level,
                             rsp.duty_a, rsp.duty_b});
          fail_cnt++;
        end else begin
          want = lamp_out_q.pop_front();
          compare_field("knob_mode", rsp.knob_mode, want.mode);
          compare_field("brightness_level", rsp.brightness_level, want.bri);
          compare_field("temperature_level", rsp.temperature_level, want.tmp);
          compare_field("duty_a", rsp.duty_a, want.duty_a);
          compare_field("duty_b", rsp.duty_b, want.duty_b);
        end
      end
    end
    open_cnt = lamp_out_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench top for the bicolor LED dimmer core. Drives a directed run of
// set, encoder and button words, then random phases under different step
// settings, with random gaps on the request side and random stalls on the
// response side. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bldc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 144;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  bit   quiet;

  bldc_req_if req ();
  bldc_rsp_if rsp ();
  bldc_cfg_if cfg ();

  bicolor_led_dimmer_control_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  bldc_checker mon (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  initial begin
    int hold;
    hold      = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        hold--;
      end else begin
        rsp.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  function automatic req_word_t make_req(logic [1:0] kind, logic [LEVEL_W-1:0] nb,
                                         logic [LEVEL_W-1:0] nt,
                                         logic signed [COUNT_W-1:0] cnt);
    req_word_t w;
    w.req_type = kind;
    w.new_bri  = nb;
    w.new_tmp  = nt;
    w.count    = cnt;
    return w;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return LEVEL_MAX;
    return LEVEL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return COUNT_W'(1);
    if (r < 45) return '1;
    if (r < 55) return '0;
    if (r < 60) return {1'b1, {(COUNT_W-1){1'b0}}};
    if (r < 65) return {1'b0, {(COUNT_W-1){1'b1}}};
    return COUNT_W'($urandom);
  endfunction

  function automatic req_word_t rand_req();
    req_word_t w;
    int        r;
    r = $urandom_range(0, 99);
    w = make_req(REQ_ENCODER, pick_level(), pick_level(), pick_count());
    if (r < 14) w.req_type = REQ_SET;
    else if (r < 22) w.req_type = REQ_BTN1;
    else if (r < 30) w.req_type = REQ_BTN2;
    return w;
  endfunction

  // present one word, hold it until taken, then maybe drop valid for a while
  task automatic send_req(req_word_t w);
    int gap;
    req.valid           <= 1'b1;
    req.req_type        <= w.req_type;
    req.new_brightness  <= w.new_bri;
    req.new_temperature <= w.new_tmp;
    req.encoder_count   <= w.count;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_steps(logic [LEVEL_W-1:0] bri_step, logic [LEVEL_W-1:0] tmp_step);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_BRI_STEP;
    cfg.data  <= bri_step;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.index <= CFG_TMP_STEP;
    cfg.data  <= tmp_step;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [LEVEL_W-1:0] bri_step;
    logic [LEVEL_W-1:0] tmp_step;
    rst                 = 1'b1;
    quiet               = 1'b0;
    req.valid           = 1'b0;
    req.req_type        = REQ_SET;
    req.new_brightness  = '0;
    req.new_temperature = '0;
    req.encoder_count   = '0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_BRI_STEP;
    cfg.data            = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encoder words with no knob mode leave the state alone
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd1));
    send_req(make_req(REQ_ENCODER, 8'd255, 8'd255, -11'sd1));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_SET, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_SET, 8'd255, 8'd255, 11'sd0));
    send_req(make_req(REQ_SET, 8'd255, 8'd0, -11'sd1024));
    // brightness mode: saturate at both ends
    send_req(make_req(REQ_BTN1, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd1));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd1023));
    send_req(make_req(REQ_SET, 8'd3, 8'd255, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, -11'sd1));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, -11'sd1024));
    // temperature mode
    send_req(make_req(REQ_BTN2, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd1));
    send_req(make_req(REQ_SET, 8'd200, 8'd2, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, -11'sd5));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_ENCODER, 8'd0, 8'd0, 11'sd1));
    send_req(make_req(REQ_BTN2, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_BTN1, 8'd0, 8'd0, 11'sd0));
    send_req(make_req(REQ_SET, 8'd0, 8'd255, 11'sd0));
    send_req(make_req(REQ_SET, 8'd255, 8'd128, 11'sd0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin bri_step = 8'd0;   tmp_step = 8'd255; end
        1:       begin bri_step = 8'd255; tmp_step = 8'd0;   end
        2:       begin bri_step = 8'd1;   tmp_step = 8'd1;   end
        3:       begin bri_step = BRI_STEP_RST; tmp_step = TMP_STEP_RST; end
        6:       begin bri_step = 8'd0;   tmp_step = 8'd0;   end
        7:       begin bri_step = 8'd255; tmp_step = 8'd255; end
        default: begin
          bri_step = LEVEL_W'($urandom_range(0, 255));
          tmp_step = LEVEL_W'($urandom_range(0, 255));
        end
      endcase
      set_steps(bri_step, tmp_step);
      // one phase runs back to back with no gaps or stalls
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_WORDS; n++) send_req(rand_req());
      drain();
      quiet = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/bldc_pkg.sv
rtl/bldc_req_if.sv
rtl/bldc_rsp_if.sv
rtl/bldc_cfg_if.sv
rtl/bldc_update.sv
rtl/bicolor_led_dimmer_control_core.sv
tb/sv/bldc_checker.sv
tb/sv/tb.sv
